// ===== rtl/sigma_clipped_mean_rms_defines.svh =====
// ----------------------------------------------------------------------------
// sigma_clipped_mean_rms_defines.svh
// Assertion macros shared by the sigma-clipped mean/rms block.
// ----------------------------------------------------------------------------
`ifndef SIGMA_CLIPPED_MEAN_RMS_DEFINES_SVH
`define SIGMA_CLIPPED_MEAN_RMS_DEFINES_SVH

// Condition must hold at every clock edge out of reset.
`define SCMR_ASSERT_ALWAYS(name, clk, rst_n, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define SCMR_ASSERT_IMPLY(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define SCMR_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/scmr_pkg.sv =====
// ----------------------------------------------------------------------------
// scmr_pkg
// Types and constants of the sigma-clipped mean/rms block.
// ----------------------------------------------------------------------------
`default_nettype none

package scmr_pkg;

    localparam int DATA_W  = 32;
    localparam int CLIP_W  = 12;
    localparam int TOL_W   = 16;
    localparam int PASS_W  = 8;
    localparam int KEPT_W  = 11;
    localparam int RMS_W   = 31;
    localparam int SQ_W    = 64;
    localparam int LIM_W   = CLIP_W + RMS_W;
    localparam int ADDR_W  = 4;
    localparam int PDATA_W = 32;

    localparam logic [CLIP_W-1:0] CLIP_SIGMA_RST    = 12'd768;
    localparam logic [TOL_W-1:0]  REL_TOLERANCE_RST = 16'd66;
    localparam logic [PASS_W-1:0] MAX_PASSES_RST    = 8'd5;

    localparam logic [RMS_W-1:0]  RMS_SAT = {RMS_W{1'b1}};

    // Register indexes (paddr[3:2])
    localparam logic [1:0] REG_CLIP_SIGMA    = 2'd0;
    localparam logic [1:0] REG_REL_TOLERANCE = 2'd1;
    localparam logic [1:0] REG_MAX_PASSES    = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SUM_GO,
        ST_SUM_WAIT,
        ST_MDIV_GO,
        ST_MDIV_WAIT,
        ST_SQ_GO,
        ST_SQ_WAIT,
        ST_VDIV_GO,
        ST_VDIV_WAIT,
        ST_SQRT_GO,
        ST_SQRT_WAIT,
        ST_SETTLE,
        ST_CHECK,
        ST_LOOP,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load_en;
        logic pass_clr;
        logic pass_begin;
        logic scan_start;
        logic scan_sq;
        logic clip_en;
        logic div_start;
        logic div_var;
        logic mean_latch;
        logic stats_zero;
        logic rms_zero;
        logic sqrt_start;
        logic rms_latch;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic scan_busy;
        logic div_busy;
        logic sqrt_busy;
        logic kept_zero;
        logic kept_lt2;
        logic tol_met;
        logic pass_lt_max;
        logic out_full;
    } status_t;

endpackage

`default_nettype wire

// ===== rtl/scmr_ram.sv =====
// ----------------------------------------------------------------------------
// scmr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module scmr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/scmr_div.sv =====
// ----------------------------------------------------------------------------
// scmr_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module scmr_div #(
    parameter int NW = 64,
    parameter int DW = 11
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [NW-1:0] num,
    input  wire logic [DW-1:0] den,
    output logic               busy,
    output logic      [NW-1:0] quo
);

    localparam int CNT_W = $clog2(NW + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic [NW-1:0]    q_reg;
    logic [DW-1:0]    rem_reg;
    logic [DW-1:0]    den_reg;
    logic [DW:0]      trial;
    logic             fits;

    assign trial = {rem_reg, q_reg[NW-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= CNT_W'(NW);
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (cnt_reg != '0)
        begin
            // shift in next dividend bit, subtract when it fits
            if (fits)
            begin
                rem_reg <= DW'(trial - {1'b0, den_reg});
            end
            else
            begin
                rem_reg <= trial[DW-1:0];
            end
            q_reg <= {q_reg[NW-2:0], fits};
        end
    end

    assign busy = cnt_reg != '0;
    assign quo  = q_reg;

endmodule

`default_nettype wire

// ===== rtl/scmr_ctrl.sv =====
// ----------------------------------------------------------------------------
// scmr_ctrl
// Sequencer: load, statistics scans, divisions, square root, pass loop.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sigma_clipped_mean_rms_defines.svh"

module scmr_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire logic             is_last,
    input  wire scmr_pkg::status_t status,
    output logic                  in_ready,
    output scmr_pkg::cmd_t        cmd
);

    import scmr_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   clip_reg;
    logic   clip_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            clip_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clip_reg  <= clip_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        clip_next  = clip_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_en = in_valid;
                if (in_valid && is_last)
                begin
                    cmd.pass_clr = 1'b1;
                    clip_next    = 1'b0;
                    state_next   = ST_SUM_GO;
                end
            end
            ST_SUM_GO:
            begin
                cmd.scan_start = 1'b1;
                cmd.clip_en    = clip_reg;
                state_next     = ST_SUM_WAIT;
            end
            ST_SUM_WAIT:
            begin
                if (!status.scan_busy)
                begin
                    if (status.kept_zero)
                    begin
                        cmd.stats_zero = 1'b1;
                        state_next     = ST_SETTLE;
                    end
                    else
                    begin
                        state_next = ST_MDIV_GO;
                    end
                end
            end
            ST_MDIV_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_MDIV_WAIT;
            end
            ST_MDIV_WAIT:
            begin
                if (!status.div_busy)
                begin
                    cmd.mean_latch = 1'b1;
                    state_next     = ST_SQ_GO;
                end
            end
            ST_SQ_GO:
            begin
                cmd.scan_start = 1'b1;
                cmd.scan_sq    = 1'b1;
                cmd.clip_en    = clip_reg;
                state_next     = ST_SQ_WAIT;
            end
            ST_SQ_WAIT:
            begin
                if (!status.scan_busy)
                begin
                    if (status.kept_lt2)
                    begin
                        cmd.rms_zero = 1'b1;
                        state_next   = ST_SETTLE;
                    end
                    else
                    begin
                        state_next = ST_VDIV_GO;
                    end
                end
            end
            ST_VDIV_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_var   = 1'b1;
                state_next    = ST_VDIV_WAIT;
            end
            ST_VDIV_WAIT:
            begin
                if (!status.div_busy)
                begin
                    state_next = ST_SQRT_GO;
                end
            end
            ST_SQRT_GO:
            begin
                cmd.sqrt_start = 1'b1;
                state_next     = ST_SQRT_WAIT;
            end
            ST_SQRT_WAIT:
            begin
                if (!status.sqrt_busy)
                begin
                    cmd.rms_latch = 1'b1;
                    state_next    = ST_SETTLE;
                end
            end
            ST_SETTLE:
            begin
                // let the tolerance compare see the new mean
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (clip_reg && status.tol_met)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_LOOP;
                end
            end
            ST_LOOP:
            begin
                if (status.pass_lt_max)
                begin
                    cmd.pass_begin = 1'b1;
                    clip_next      = 1'b1;
                    state_next     = ST_SUM_GO;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!status.out_full)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `SCMR_ASSERT_IMPLY(a_out_load_empty, clk, rst_n, cmd.out_load, !status.out_full,
        "result loaded over a pending transaction")
    `SCMR_ASSERT_IMPLY(a_scan_idle_units, clk, rst_n, cmd.scan_start,
        !status.scan_busy && !status.div_busy && !status.sqrt_busy,
        "scan started while a unit is busy")
    `SCMR_ASSERT_NEXT(a_last_starts, clk, rst_n, in_valid && in_ready && is_last,
        state_reg == ST_SUM_GO, "last sample did not start computation")

endmodule

`default_nettype wire

// ===== rtl/scmr_dp.sv =====
// ----------------------------------------------------------------------------
// scmr_dp
// Datapath: sample store, scan pipeline, accumulators, divider, square root,
// tolerance compare and result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sigma_clipped_mean_rms_defines.svh"

module scmr_dp #(
    parameter int DEPTH = 1024
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire scmr_pkg::cmd_t                        cmd,
    output scmr_pkg::status_t                          status,
    input  wire logic        [scmr_pkg::CLIP_W-1:0]    clip_sigma,
    input  wire logic        [scmr_pkg::TOL_W-1:0]     rel_tolerance,
    input  wire logic        [scmr_pkg::PASS_W-1:0]    max_passes,
    input  wire logic signed [scmr_pkg::DATA_W-1:0]    sample,
    input  wire logic                                  sample_defined,
    input  wire logic                                  out_ready,
    output logic                                       out_valid,
    output logic signed      [scmr_pkg::DATA_W-1:0]    clipped_mean,
    output logic             [scmr_pkg::RMS_W-1:0]     clipped_rms,
    output logic             [scmr_pkg::KEPT_W-1:0]    kept_count,
    output logic             [scmr_pkg::PASS_W-1:0]    passes_run,
    output logic                                       store_overflow,
    output logic                                       too_few
);

    import scmr_pkg::*;

    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int SUM_W = DATA_W + CW;

    // store fill
    logic [CW-1:0] count_reg;
    logic          ovf_reg;
    logic          full;
    logic          wr_en;

    // scan pipeline
    logic                     issue_reg;
    logic [AW-1:0]            addr_reg;
    logic                     mode_sq_reg;
    logic                     clip_reg;
    logic                     v1_reg, v2_reg, v3_reg, v4_reg;
    logic signed [DATA_W-1:0] rd_data;
    logic signed [DATA_W-1:0] x2_reg, x3_reg;
    logic [DATA_W-1:0]        dclip2_reg;
    logic [DATA_W-1:0]        dmean2_reg, dmean3_reg;
    logic [SQ_W-1:0]          prod4_reg;
    logic signed [DATA_W:0]   dif_clip, dif_mean;
    logic                     keep2;

    // statistics
    logic signed [SUM_W-1:0]  sum_reg;
    logic [CW-1:0]            cnt_reg;
    logic [SQ_W-1:0]          sq_reg;
    logic [SQ_W:0]            sq_sum;
    logic signed [DATA_W-1:0] mean_reg;
    logic signed [DATA_W-1:0] prev_reg;
    logic [RMS_W-1:0]         rms_reg;
    logic [LIM_W-1:0]         lim_reg;
    logic [PASS_W-1:0]        pass_reg;
    logic                     tol_met_reg;

    // divider
    logic [SUM_W-1:0] abs_sum;
    logic [SQ_W-1:0]  div_num;
    logic [CW-1:0]    div_den;
    logic             div_busy;
    logic [SQ_W-1:0]  div_quo;
    logic [DATA_W:0]  mean_mag;

    // square root
    logic [SQ_W-1:0]   rad_reg;
    logic [34:0]       srem_reg;
    logic [31:0]       root_reg;
    logic [5:0]        scnt_reg;
    logic              var_hi_reg;
    logic [34:0]       srem_sh;
    logic [34:0]       strial;

    // tolerance compare
    logic signed [DATA_W:0] dif_tol;
    logic [DATA_W-1:0]      tol_diff_abs;
    logic [DATA_W-1:0]      prev_abs;
    logic [47:0]            tol_lhs;
    logic [47:0]            tol_rhs;

    // result register
    logic                     out_valid_reg;
    logic signed [DATA_W-1:0] o_mean_reg;
    logic [RMS_W-1:0]         o_rms_reg;
    logic [KEPT_W-1:0]        o_kept_reg;
    logic [PASS_W-1:0]        o_pass_reg;
    logic                     o_ovf_reg;
    logic                     o_few_reg;

    // ------------------------------------------------------------------ store
    assign full  = count_reg == CW'(DEPTH);
    assign wr_en = cmd.load_en && sample_defined && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (cmd.load_en && sample_defined)
        begin
            if (full)
            begin
                ovf_reg <= 1'b1;
            end
            else
            begin
                count_reg <= count_reg + CW'(1);
            end
        end
    end

    scmr_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (sample),
        .rd_en   (issue_reg),
        .rd_addr (addr_reg),
        .rd_data (rd_data)
    );

    // ------------------------------------------------------------- scan issue
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_reg <= 1'b0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            v4_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.scan_start)
            begin
                issue_reg <= count_reg != '0;
            end
            else if (issue_reg && (CW'(addr_reg) + CW'(1) == count_reg))
            begin
                issue_reg <= 1'b0;
            end
            v1_reg <= issue_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg && keep2;
            v4_reg <= v3_reg && mode_sq_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_start)
        begin
            addr_reg    <= '0;
            mode_sq_reg <= cmd.scan_sq;
            clip_reg    <= cmd.clip_en;
        end
        else if (issue_reg)
        begin
            addr_reg <= addr_reg + AW'(1);
        end
    end

    // ---------------------------------------------------------- scan pipeline
    assign dif_clip = {rd_data[DATA_W-1], rd_data} - {prev_reg[DATA_W-1], prev_reg};
    assign dif_mean = {rd_data[DATA_W-1], rd_data} - {mean_reg[DATA_W-1], mean_reg};
    assign keep2    = !clip_reg || ({3'b000, dclip2_reg, 8'h00} <= lim_reg);

    always_ff @(posedge clk)
    begin
        x2_reg     <= rd_data;
        dclip2_reg <= dif_clip[DATA_W] ? DATA_W'(-dif_clip) : dif_clip[DATA_W-1:0];
        dmean2_reg <= dif_mean[DATA_W] ? DATA_W'(-dif_mean) : dif_mean[DATA_W-1:0];
        x3_reg     <= x2_reg;
        dmean3_reg <= dmean2_reg;
        prod4_reg  <= SQ_W'(dmean3_reg) * SQ_W'(dmean3_reg);
    end

    // ------------------------------------------------------------ accumulators
    assign sq_sum = {1'b0, sq_reg} + (SQ_W + 1)'(prod4_reg >> 16);

    always_ff @(posedge clk)
    begin
        if (cmd.scan_start && !cmd.scan_sq)
        begin
            sum_reg <= '0;
            cnt_reg <= '0;
        end
        else if (v3_reg && !mode_sq_reg)
        begin
            sum_reg <= sum_reg + SUM_W'(x3_reg);
            cnt_reg <= cnt_reg + CW'(1);
        end

        if (cmd.scan_start && cmd.scan_sq)
        begin
            sq_reg <= '0;
        end
        else if (v4_reg)
        begin
            // saturate on carry out
            sq_reg <= sq_sum[SQ_W] ? {SQ_W{1'b1}} : sq_sum[SQ_W-1:0];
        end
    end

    // ---------------------------------------------------------------- divider
    assign abs_sum = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign div_num = cmd.div_var ? sq_reg : SQ_W'(abs_sum) + SQ_W'(cnt_reg >> 1);
    assign div_den = cmd.div_var ? cnt_reg - CW'(1) : cnt_reg;

    scmr_div #(
        .NW (SQ_W),
        .DW (CW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .quo   (div_quo)
    );

    assign mean_mag = div_quo[DATA_W:0];

    // ------------------------------------------------------------ square root
    assign srem_sh = {srem_reg[32:0], rad_reg[SQ_W-1:SQ_W-2]};
    assign strial  = {1'b0, root_reg, 2'b01};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scnt_reg <= '0;
        end
        else if (cmd.sqrt_start)
        begin
            scnt_reg <= 6'd32;
        end
        else if (scnt_reg != '0)
        begin
            scnt_reg <= scnt_reg - 6'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sqrt_start)
        begin
            rad_reg    <= {div_quo[47:0], 16'h0000};
            var_hi_reg <= div_quo[SQ_W-1:48] != '0;
            srem_reg   <= '0;
            root_reg   <= '0;
        end
        else if (scnt_reg != '0)
        begin
            rad_reg <= {rad_reg[SQ_W-3:0], 2'b00};
            if (srem_sh >= strial)
            begin
                srem_reg <= srem_sh - strial;
                root_reg <= {root_reg[30:0], 1'b1};
            end
            else
            begin
                srem_reg <= srem_sh;
                root_reg <= {root_reg[30:0], 1'b0};
            end
        end
    end

    // ------------------------------------------------------ mean, rms, passes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mean_reg <= '0;
            prev_reg <= '0;
            rms_reg  <= '0;
            pass_reg <= '0;
        end
        else
        begin
            if (cmd.stats_zero)
            begin
                mean_reg <= '0;
            end
            else if (cmd.mean_latch)
            begin
                mean_reg <= sum_reg[SUM_W-1] ? DATA_W'(-mean_mag) : DATA_W'(mean_mag);
            end

            if (cmd.stats_zero || cmd.rms_zero)
            begin
                rms_reg <= '0;
            end
            else if (cmd.rms_latch)
            begin
                rms_reg <= (var_hi_reg || root_reg[31]) ? RMS_SAT : root_reg[RMS_W-1:0];
            end

            if (cmd.pass_clr)
            begin
                pass_reg <= '0;
            end
            else if (cmd.pass_begin)
            begin
                pass_reg <= pass_reg + PASS_W'(1);
                prev_reg <= mean_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pass_begin)
        begin
            lim_reg <= LIM_W'(clip_sigma) * LIM_W'(rms_reg);
        end
    end

    // ------------------------------------------------------ tolerance compare
    assign dif_tol      = {prev_reg[DATA_W-1], prev_reg} - {mean_reg[DATA_W-1], mean_reg};
    assign tol_diff_abs = dif_tol[DATA_W] ? DATA_W'(-dif_tol) : dif_tol[DATA_W-1:0];
    assign prev_abs     = prev_reg[DATA_W-1] ? DATA_W'(-prev_reg) : DATA_W'(prev_reg);
    assign tol_lhs      = {tol_diff_abs, 16'h0000};
    assign tol_rhs      = 48'(rel_tolerance) * 48'(prev_abs);

    always_ff @(posedge clk)
    begin
        tol_met_reg <= tol_lhs < tol_rhs;
    end

    // -------------------------------------------------------- result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            o_mean_reg <= mean_reg;
            o_rms_reg  <= rms_reg;
            o_kept_reg <= KEPT_W'(cnt_reg);
            o_pass_reg <= pass_reg;
            o_ovf_reg  <= ovf_reg;
            o_few_reg  <= cnt_reg < CW'(2);
        end
    end

    assign out_valid      = out_valid_reg;
    assign clipped_mean   = o_mean_reg;
    assign clipped_rms    = o_rms_reg;
    assign kept_count     = o_kept_reg;
    assign passes_run     = o_pass_reg;
    assign store_overflow = o_ovf_reg;
    assign too_few        = o_few_reg;

    // ----------------------------------------------------------------- status
    assign status.scan_busy   = issue_reg || v1_reg || v2_reg || v3_reg || v4_reg;
    assign status.div_busy    = div_busy;
    assign status.sqrt_busy   = scnt_reg != '0;
    assign status.kept_zero   = cnt_reg == '0;
    assign status.kept_lt2    = cnt_reg < CW'(2);
    assign status.tol_met     = tol_met_reg;
    assign status.pass_lt_max = pass_reg < max_passes;
    assign status.out_full    = out_valid_reg;

    `SCMR_ASSERT_ALWAYS(a_units_exclusive, clk, rst_n,
        !(status.scan_busy && (div_busy || status.sqrt_busy)),
        "scan overlaps divider or square root")
    `SCMR_ASSERT_ALWAYS(a_count_le_depth, clk, rst_n, count_reg <= CW'(DEPTH),
        "stored count exceeds store depth")

endmodule

`default_nettype wire

// ===== rtl/sigma_clipped_mean_rms.sv =====
// Load: one sample per cycle; in_ready is high in idle, low from the last sample to the result.
// Each round: sum scan, mean division, square scan, variance division, square root and pass
// control; too few kept samples skip the later steps of the round.
// The result waits in the output register while the next set loads; a full register stalls.
// Reset (rst_n, async low) empties the store and restores register defaults.
// ----------------------------------------------------------------------------
// sigma_clipped_mean_rms
// Iterative sigma-clipped mean and sample standard deviation, with APB
// configuration of clip width, relative tolerance and pass limit.
// ----------------------------------------------------------------------------
`default_nettype none

module sigma_clipped_mean_rms #(
    parameter int DEPTH = 1024
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic        [scmr_pkg::ADDR_W-1:0]    paddr,
    input  wire logic        [scmr_pkg::PDATA_W-1:0]   pwdata,
    output logic             [scmr_pkg::PDATA_W-1:0]   prdata,
    output logic                                       pready,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic signed [scmr_pkg::DATA_W-1:0]    sample,
    input  wire logic                                  sample_defined,
    input  wire logic                                  is_last,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic signed      [scmr_pkg::DATA_W-1:0]    clipped_mean,
    output logic             [scmr_pkg::RMS_W-1:0]     clipped_rms,
    output logic             [scmr_pkg::KEPT_W-1:0]    kept_count,
    output logic             [scmr_pkg::PASS_W-1:0]    passes_run,
    output logic                                       store_overflow,
    output logic                                       too_few
);

    import scmr_pkg::*;

    logic [CLIP_W-1:0] clip_sigma_reg;
    logic [TOL_W-1:0]  rel_tolerance_reg;
    logic [PASS_W-1:0] max_passes_reg;
    logic              cfg_wr;
    logic [1:0]        reg_index;
    cmd_t              cmd;
    status_t           status;

    // ---------------------------------------------------------- config port
    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite;
    assign reg_index = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_sigma_reg    <= CLIP_SIGMA_RST;
            rel_tolerance_reg <= REL_TOLERANCE_RST;
            max_passes_reg    <= MAX_PASSES_RST;
        end
        else if (cfg_wr)
        begin
            case (reg_index)
                REG_CLIP_SIGMA:    clip_sigma_reg    <= pwdata[CLIP_W-1:0];
                REG_REL_TOLERANCE: rel_tolerance_reg <= pwdata[TOL_W-1:0];
                REG_MAX_PASSES:    max_passes_reg    <= pwdata[PASS_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            REG_CLIP_SIGMA:    prdata = PDATA_W'(clip_sigma_reg);
            REG_REL_TOLERANCE: prdata = PDATA_W'(rel_tolerance_reg);
            REG_MAX_PASSES:    prdata = PDATA_W'(max_passes_reg);
            default:           prdata = '0;
        endcase
    end

    // ---------------------------------------------------- control + datapath
    scmr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .is_last  (is_last),
        .status   (status),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    scmr_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .clip_sigma     (clip_sigma_reg),
        .rel_tolerance  (rel_tolerance_reg),
        .max_passes     (max_passes_reg),
        .sample         (sample),
        .sample_defined (sample_defined),
        .out_ready      (out_ready),
        .out_valid      (out_valid),
        .clipped_mean   (clipped_mean),
        .clipped_rms    (clipped_rms),
        .kept_count     (kept_count),
        .passes_run     (passes_run),
        .store_overflow (store_overflow),
        .too_few        (too_few)
    );

endmodule

`default_nettype wire
